// File: design/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU core.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               divide_by_zero;
    } alu_rsp_t;

    // Per-item side data that rides along the divider chain
    typedef struct packed {
        cmd_t        command;
        logic [31:0] value;
        logic        compare_true;
        logic        divide_by_zero;
        logic        quot_neg;
    } side_t;

endpackage

// File: design/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Two-stage front end: simple ops, compares, 32x32 product, divider setup.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = 32 + FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpa_pkg::alu_req_t req,
    output logic              out_valid,
    output fpa_pkg::side_t    out_side,
    output logic [DW-1:0]     out_dq,
    output logic [31:0]       out_divisor
);
    import fpa_pkg::*;

    logic signed [31:0] a;
    logic signed [31:0] b;
    side_t              s1_next;
    logic [31:0]        amag;
    logic [31:0]        bmag;

    logic               s1_valid_reg;
    side_t              s1_side_reg;
    logic signed [63:0] s1_prod_reg;
    logic [DW-1:0]      s1_dq_reg;
    logic [31:0]        s1_div_reg;

    logic               s2_valid_reg;
    side_t              s2_side_reg;
    logic [DW-1:0]      s2_dq_reg;
    logic [31:0]        s2_div_reg;
    side_t              s2_next;

    assign a    = req.operand_a;
    assign b    = req.operand_b;
    assign amag = a[31] ? 32'(-a) : a;
    assign bmag = b[31] ? 32'(-b) : b;

    always_comb
    begin
        s1_next                = '0;
        s1_next.command        = req.command;
        s1_next.quot_neg       = a[31] ^ b[31];
        unique case (req.command)
            CMD_ADD:      s1_next.value = a + b;
            CMD_SUB:      s1_next.value = a - b;
            CMD_MUL:      s1_next.value = '0;
            CMD_DIV:      s1_next.divide_by_zero = (b == 32'sd0);
            CMD_GT:       s1_next.compare_true = (a > b);
            CMD_LT:       s1_next.compare_true = (a < b);
            CMD_GE:       s1_next.compare_true = (a >= b);
            CMD_LE:       s1_next.compare_true = (a <= b);
            CMD_EQ:       s1_next.compare_true = (a == b);
            CMD_NE:       s1_next.compare_true = (a != b);
            CMD_MIN:      s1_next.value = (a < b) ? a : b;
            CMD_MAX:      s1_next.value = (a > b) ? a : b;
            CMD_INC:      s1_next.value = a + 32'sd1;
            CMD_DEC:      s1_next.value = a - 32'sd1;
            CMD_FROM_INT: s1_next.value = a << FRAC_BITS;
            CMD_TO_INT:   s1_next.value = a >>> FRAC_BITS;
        endcase
    end

    // Product is floor-shifted one stage after the multiply
    always_comb
    begin
        s2_next = s1_side_reg;
        if (s1_side_reg.command == CMD_MUL)
        begin
            s2_next.value = s1_prod_reg[FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= s1_next;
        s1_prod_reg <= a * b;
        s1_dq_reg   <= {amag, {FRAC_BITS{1'b0}}};
        s1_div_reg  <= bmag;
        s2_side_reg <= s2_next;
        s2_dq_reg   <= s1_dq_reg;
        s2_div_reg  <= s1_div_reg;
    end

    assign out_valid   = s2_valid_reg;
    assign out_side    = s2_side_reg;
    assign out_dq      = s2_dq_reg;
    assign out_divisor = s2_div_reg;

endmodule

// File: design/fpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module fpa_cell #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = 32 + FRAC_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fpa_pkg::side_t in_side,
    input  logic [DW-1:0]  in_dq,
    input  logic [31:0]    in_rem,
    input  logic [31:0]    in_divisor,
    output logic           out_valid,
    output fpa_pkg::side_t out_side,
    output logic [DW-1:0]  out_dq,
    output logic [31:0]    out_rem,
    output logic [31:0]    out_divisor
);
    import fpa_pkg::*;

    logic [32:0]   trial;
    logic          q_bit;
    logic          valid_reg;
    side_t         side_reg;
    logic [DW-1:0] dq_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   div_reg;

    // dq holds remaining dividend bits on top, quotient bits shift in below
    assign trial = {in_rem, in_dq[DW-1]} - {1'b0, in_divisor};
    assign q_bit = !trial[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        dq_reg   <= {in_dq[DW-2:0], q_bit};
        rem_reg  <= q_bit ? trial[31:0] : {in_rem[30:0], in_dq[DW-1]};
        div_reg  <= in_divisor;
    end

    assign out_valid   = valid_reg;
    assign out_side    = side_reg;
    assign out_dq      = dq_reg;
    assign out_rem     = rem_reg;
    assign out_divisor = div_reg;

endmodule

// File: design/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Quotient sign fix, result select and output register.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    localparam int DW = 32 + FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpa_pkg::side_t    in_side,
    input  logic [DW-1:0]     in_quot,
    output logic              done,
    output fpa_pkg::alu_rsp_t result
);
    import fpa_pkg::*;

    logic [31:0] q32;
    alu_rsp_t    rsp_next;
    alu_rsp_t    rsp_reg;
    logic        done_reg;

    assign q32 = in_quot[31:0];

    always_comb
    begin
        rsp_next.compare_true   = in_side.compare_true;
        rsp_next.divide_by_zero = in_side.divide_by_zero;
        if (in_side.divide_by_zero)
        begin
            rsp_next.result_value = '0;
        end
        else if (in_side.command == CMD_DIV)
        begin
            rsp_next.result_value = in_side.quot_neg ? -q32 : q32;
        end
        else
        begin
            rsp_next.result_value = in_side.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// File: design/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request and pulse start; a transfer happens on each edge with start
//   high (busy is always low, so one command may be issued every cycle).
//   Each command yields one result on the result port, marked by done for a
//   single cycle. The receiver cannot stall; results must be taken as shown.
//   Every command passes through the same path: two front stages (multiply,
//   then product shift), one divider cell per quotient bit of the 32+FRAC_BITS
//   bit dividend, and the output register.
//   All commands share the divider chain so results leave in issue order.
//   Throughput is one command per cycle.
//   Reset clears all valid flags; items in flight are dropped and no done
//   pulse appears until a new command is issued.
// ----------------------------------------------------------------------------
module fixed_point_alu_core #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::alu_req_t request,
    output logic              done,
    output fpa_pkg::alu_rsp_t result
);
    import fpa_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    logic          ch_valid   [DW+1];
    side_t         ch_side    [DW+1];
    logic [DW-1:0] ch_dq      [DW+1];
    logic [31:0]   ch_rem     [DW+1];
    logic [31:0]   ch_divisor [DW+1];

    assign busy      = 1'b0;
    assign ch_rem[0] = '0;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .req         (request),
        .out_valid   (ch_valid[0]),
        .out_side    (ch_side[0]),
        .out_dq      (ch_dq[0]),
        .out_divisor (ch_divisor[0])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        fpa_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (ch_valid[i]),
            .in_side     (ch_side[i]),
            .in_dq       (ch_dq[i]),
            .in_rem      (ch_rem[i]),
            .in_divisor  (ch_divisor[i]),
            .out_valid   (ch_valid[i+1]),
            .out_side    (ch_side[i+1]),
            .out_dq      (ch_dq[i+1]),
            .out_rem     (ch_rem[i+1]),
            .out_divisor (ch_divisor[i+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ch_valid[DW]),
        .in_side  (ch_side[DW]),
        .in_quot  (ch_dq[DW]),
        .done     (done),
        .result   (result)
    );

endmodule

// File: design/fpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fixed-point ALU core.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input fpa_pkg::alu_rsp_t result
);
    import fpa_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.compare_true && result.divide_by_zero))
        else $error("compare and divide-by-zero flags both set");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.result_value == 32'sd0))
        else $error("nonzero result on zero divisor");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.compare_true) |-> (result.result_value == 32'sd0))
        else $error("nonzero result on true compare");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
